// ----- rtl/core/nprs_pkg.sv -----
// Shared types, codes and constants of the NAND page read sequencer.
`default_nettype none

package nprs_pkg;

   // Page size used when the top level is not told otherwise; must be a power of two.
   localparam int unsigned PAGE_BYTES_DEFAULT = 2048;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   // Request command codes.
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_START  = 2'd0;
   localparam cmd_type CMD_STATUS = 2'd1;
   localparam cmd_type CMD_DATA   = 2'd2;

   // Response operation codes.
   typedef logic [2:0] op_type;
   localparam op_type OP_SEL   = 3'd0;
   localparam op_type OP_CMD   = 3'd1;
   localparam op_type OP_ADR   = 3'd2;
   localparam op_type OP_STORE = 3'd3;
   localparam op_type OP_DESEL = 3'd4;

   // Flash command bytes of a large-page read.
   localparam byte_type NAND_READ0     = 8'h00;
   localparam byte_type NAND_READSTART = 8'h30;

endpackage

`default_nettype wire

// ----- rtl/core/nprs_if.sv -----
// Request and response channel interfaces of the NAND page read sequencer.
`default_nettype none

interface nprs_req_if
   import nprs_pkg::*;
   ();
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   word_type start_addr;
   word_type length;
   logic     ready_flag;
   byte_type flash_byte;

   modport source (output valid, output cmd, output start_addr, output length,
                   output ready_flag, output flash_byte, input ready);
   modport sink   (input valid, input cmd, input start_addr, input length,
                   input ready_flag, input flash_byte, output ready);
endinterface

interface nprs_rsp_if
   import nprs_pkg::*;
   ();
   logic     valid;
   logic     ready;
   op_type   op;
   byte_type bus_byte;
   word_type buf_index;
   logic     last;

   modport source (output valid, output op, output bus_byte, output buf_index,
                   output last, input ready);
   modport sink   (input valid, input op, input bus_byte, input buf_index,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nand_page_read_sequencer.sv -----
// Latency: a request transaction is decoded in the cycle it is accepted; its first response is
// valid in the next cycle. A transaction yields zero to eight responses, one per cycle while the
// response port is ready. Throughput: one request per cycle while each yields at most one response
// and the port is ready; a select or page-boundary burst holds off requests until it completes.
// Reset is synchronous and active high: the sequencer returns to idle with no response pending.
`default_nettype none

module nand_page_read_sequencer
   import nprs_pkg::*;
   #(
      parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEFAULT
   )
   (
      input  wire logic   clock,
      input  wire logic   reset,
      nprs_req_if.sink    req_if,
      nprs_rsp_if.source  rsp_if
   );

   // The page size is a power of two, so the column is the low address bits and the page
   // number is the rest of the address.
   localparam int unsigned PageBits = $clog2(PAGE_BYTES);

   // Positions in the response sequence of one request. Position zero is the lead response
   // (select or store); a deselect follows at position one, or a full command and address
   // burst fills positions one through seven.
   localparam logic [2:0] POS_LEAD      = 3'd0;
   localparam logic [2:0] POS_CMD_READ  = 3'd1;
   localparam logic [2:0] POS_COL_LO    = 3'd2;
   localparam logic [2:0] POS_COL_HI    = 3'd3;
   localparam logic [2:0] POS_PAGE_B0   = 3'd4;
   localparam logic [2:0] POS_PAGE_B1   = 3'd5;
   localparam logic [2:0] POS_PAGE_B2   = 3'd6;
   localparam logic [2:0] POS_CMD_START = 3'd7;
   localparam logic [2:0] POS_DESEL     = 3'd1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_DESEL,
      TAIL_BURST
   } tail_type;

   // Read progress state.
   phase_type phase_ff, phase_in;
   word_type  cur_addr_ff, cur_addr_in;
   word_type  byte_count_ff, byte_count_in;
   word_type  total_len_ff, total_len_in;

   // Response sequence register: what the accepted transaction must still emit.
   logic      busy_ff, busy_in;
   logic [2:0] pos_ff, pos_in;
   logic      lead_store_ff, lead_store_in;
   tail_type  tail_ff, tail_in;
   byte_type  data_ff, data_in;
   word_type  index_ff, index_in;
   word_type  baddr_ff, baddr_in;

   logic       accept;
   logic       rsp_done;
   logic [2:0] last_pos;
   word_type   count_next;
   word_type   addr_next;
   logic [15:0] column;
   word_type   page;

   always_comb begin
      case (tail_ff)
         TAIL_DESEL: last_pos = POS_DESEL;
         TAIL_BURST: last_pos = POS_CMD_START;
         default:    last_pos = POS_LEAD;
      endcase
   end

   // A new request is taken while the final response of the previous one is handed off,
   // so single-response transactions stream at full rate.
   assign rsp_done     = busy_ff && rsp_if.ready && (pos_ff == last_pos);
   assign req_if.ready = !busy_ff || rsp_done;
   assign accept       = req_if.valid && req_if.ready;

   assign count_next = byte_count_ff + 32'd1;
   assign addr_next  = cur_addr_ff + 32'd1;

   // Decode of an accepted request together with the progress of the response sequence.
   always_comb begin
      phase_in      = phase_ff;
      cur_addr_in   = cur_addr_ff;
      byte_count_in = byte_count_ff;
      total_len_in  = total_len_ff;
      busy_in       = busy_ff;
      pos_in        = pos_ff;
      lead_store_in = lead_store_ff;
      tail_in       = tail_ff;
      data_in       = data_ff;
      index_in      = index_ff;
      baddr_in      = baddr_ff;

      if (busy_ff && rsp_if.ready) begin
         if (pos_ff == last_pos) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end

      if (accept) begin
         case (req_if.cmd)
            CMD_START: begin
               if (phase_ff == PH_IDLE) begin
                  cur_addr_in   = req_if.start_addr;
                  total_len_in  = req_if.length;
                  byte_count_in = '0;
                  busy_in       = 1'b1;
                  pos_in        = POS_LEAD;
                  lead_store_in = 1'b0;
                  baddr_in      = req_if.start_addr;
                  if (req_if.length == '0) begin
                     tail_in = TAIL_DESEL;
                  end else begin
                     tail_in  = TAIL_BURST;
                     phase_in = PH_WAIT;
                  end
               end
            end
            CMD_STATUS: begin
               if (phase_ff == PH_WAIT && req_if.ready_flag) begin
                  phase_in = PH_DATA;
               end
            end
            CMD_DATA: begin
               if (phase_ff == PH_DATA) begin
                  byte_count_in = count_next;
                  cur_addr_in   = addr_next;
                  busy_in       = 1'b1;
                  pos_in        = POS_LEAD;
                  lead_store_in = 1'b1;
                  data_in       = req_if.flash_byte;
                  index_in      = byte_count_ff;
                  baddr_in      = addr_next;
                  if (count_next == total_len_ff) begin
                     // The final byte closes the read with a deselect.
                     tail_in  = TAIL_DESEL;
                     phase_in = PH_IDLE;
                  end else if (addr_next[PageBits-1:0] == '0) begin
                     // Crossing into a new page reissues the read command and address.
                     tail_in  = TAIL_BURST;
                     phase_in = PH_WAIT;
                  end else begin
                     tail_in = TAIL_NONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         cur_addr_ff   <= '0;
         byte_count_ff <= '0;
         total_len_ff  <= '0;
         busy_ff       <= 1'b0;
         pos_ff        <= POS_LEAD;
         lead_store_ff <= 1'b0;
         tail_ff       <= TAIL_NONE;
      end else begin
         phase_ff      <= phase_in;
         cur_addr_ff   <= cur_addr_in;
         byte_count_ff <= byte_count_in;
         total_len_ff  <= total_len_in;
         busy_ff       <= busy_in;
         pos_ff        <= pos_in;
         lead_store_ff <= lead_store_in;
         tail_ff       <= tail_in;
      end
      data_ff  <= data_in;
      index_ff <= index_in;
      baddr_ff <= baddr_in;
   end

   // Column and page number of the burst address.
   assign column = {{(16 - PageBits){1'b0}}, baddr_ff[PageBits-1:0]};
   assign page   = baddr_ff >> PageBits;

   // Response fields are selected from the sequence register by position.
   always_comb begin
      rsp_if.valid     = busy_ff;
      rsp_if.op        = OP_SEL;
      rsp_if.bus_byte  = '0;
      rsp_if.buf_index = '0;
      rsp_if.last      = 1'b0;
      if (pos_ff == POS_LEAD) begin
         if (lead_store_ff) begin
            rsp_if.op        = OP_STORE;
            rsp_if.bus_byte  = data_ff;
            rsp_if.buf_index = index_ff;
         end
      end else if (tail_ff == TAIL_DESEL) begin
         rsp_if.op   = OP_DESEL;
         rsp_if.last = 1'b1;
      end else begin
         case (pos_ff)
            POS_CMD_READ: begin
               rsp_if.op       = OP_CMD;
               rsp_if.bus_byte = NAND_READ0;
            end
            POS_COL_LO: begin
               rsp_if.op       = OP_ADR;
               rsp_if.bus_byte = column[7:0];
            end
            POS_COL_HI: begin
               rsp_if.op       = OP_ADR;
               rsp_if.bus_byte = column[15:8];
            end
            POS_PAGE_B0: begin
               rsp_if.op       = OP_ADR;
               rsp_if.bus_byte = page[7:0];
            end
            POS_PAGE_B1: begin
               rsp_if.op       = OP_ADR;
               rsp_if.bus_byte = page[15:8];
            end
            POS_PAGE_B2: begin
               rsp_if.op       = OP_ADR;
               rsp_if.bus_byte = page[23:16];
            end
            POS_CMD_START: begin
               rsp_if.op       = OP_CMD;
               rsp_if.bus_byte = NAND_READSTART;
            end
            default: begin
               rsp_if.op = OP_SEL;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
